/* hw/rtl/afss_pkg.sv */
// Shared constants, codes and helpers for the autofocus search sequencer.
package afss_pkg;

  localparam int Z_W     = 24;
  localparam int ZX_W    = Z_W + 3;
  localparam int SCORE_W = 32;
  localparam int FRAME_W = 16;

  localparam logic signed [ZX_W-1:0] ZMAX_X = (ZX_W)'((64'sd1 <<< (Z_W - 1)) - 64'sd1);
  localparam logic signed [ZX_W-1:0] ZMIN_X = -ZMAX_X - (ZX_W)'(1);

  // register indexes
  localparam logic [2:0] REG_HALF_RANGE = 3'd0;
  localparam logic [2:0] REG_COARSE     = 3'd1;
  localparam logic [2:0] REG_FINE       = 3'd2;
  localparam logic [2:0] REG_MAX_FINE   = 3'd3;
  localparam logic [2:0] REG_VERIFY_EN  = 3'd4;
  localparam logic [2:0] REG_SPAN       = 3'd5;
  localparam logic [2:0] REG_RATIO      = 3'd6;

  // commands
  localparam logic [1:0] CMD_SWEEP = 2'd0;
  localparam logic [1:0] CMD_MAP   = 2'd1;
  localparam logic [1:0] CMD_SCORE = 2'd2;

  // search phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_TRUST   = 3'd1;
  localparam logic [2:0] PH_VLO     = 3'd2;
  localparam logic [2:0] PH_VMID    = 3'd3;
  localparam logic [2:0] PH_VHI     = 3'd4;
  localparam logic [2:0] PH_CONFIRM = 3'd5;
  localparam logic [2:0] PH_COARSE  = 3'd6;
  localparam logic [2:0] PH_CLIMB   = 3'd7;

  function automatic logic signed [Z_W-1:0] clampz(input logic signed [ZX_W-1:0] v);
    if (v < ZMIN_X) return ZMIN_X[Z_W-1:0];
    if (v > ZMAX_X) return ZMAX_X[Z_W-1:0];
    return v[Z_W-1:0];
  endfunction

  function automatic logic signed [ZX_W-1:0] zext(input logic signed [Z_W-1:0] z);
    return {{(ZX_W-Z_W){z[Z_W-1]}}, z};
  endfunction

endpackage

/* hw/rtl/autofocus_search_sequencer.sv */
// Autofocus search sequencer: coarse sweep, fine hill climb and map check.
// A start or score item has its result registered in the execute state, or in the climb state
// when the fine climb decides it, also after a turn-around there; the last verify report goes
// through the multiply step and decision to a fall-back sweep, or else on through a 48-step
// shift-subtract divider for the vertex offset. A stalled output holds the result back.
// One item is worked on at a time; the next is taken once the sequencer is back in
// its wait state, while a finished result may still sit in the output register.
// Reset (rst_n low, synchronous) clears the search to idle and reloads register defaults.
module autofocus_search_sequencer
  import afss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // start_z[23:0], exp score[55:24], frame score[87:56]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // target_z[23:0], best_score[55:24], frame_count[71:56]
  output logic [1:0]  out_tuser,  // kind[0], sweep flag[1]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] S_WAIT = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CLIMB = 3'd2;
  localparam logic [2:0] S_VMUL = 3'd3;
  localparam logic [2:0] S_VDEC = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_VERT = 3'd6;

  // configuration
  logic [19:0] half_r;
  logic [15:0] coarse_r, fine_r, span_r, ratio_r;
  logic [7:0]  max_fine_r;
  logic        verify_en_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 20'd2000;
      coarse_r <= 16'd200;
      fine_r <= 16'd25;
      max_fine_r <= 8'd8;
      verify_en_r <= 1'b1;
      span_r <= 16'd100;
      ratio_r <= 16'd5243;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_HALF_RANGE: half_r <= cfg_pwdata[19:0];
        REG_COARSE:     coarse_r <= cfg_pwdata[15:0];
        REG_FINE:       fine_r <= cfg_pwdata[15:0];
        REG_MAX_FINE:   max_fine_r <= cfg_pwdata[7:0];
        REG_VERIFY_EN:  verify_en_r <= cfg_pwdata[0];
        REG_SPAN:       span_r <= cfg_pwdata[15:0];
        REG_RATIO:      ratio_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_HALF_RANGE: cfg_prdata = {12'd0, half_r};
      REG_COARSE:     cfg_prdata = {16'd0, coarse_r};
      REG_FINE:       cfg_prdata = {16'd0, fine_r};
      REG_MAX_FINE:   cfg_prdata = {24'd0, max_fine_r};
      REG_VERIFY_EN:  cfg_prdata = {31'd0, verify_en_r};
      REG_SPAN:       cfg_prdata = {16'd0, span_r};
      REG_RATIO:      cfg_prdata = {16'd0, ratio_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // state
  logic [2:0] st_r, st_nxt, phase_r, phase_nxt;
  logic signed [Z_W-1:0] probe_r, probe_nxt, centre_r, centre_nxt, winner_z_r, winner_z_nxt;
  logic signed [Z_W-1:0] climb_z_r, climb_z_nxt, base_z_r, base_z_nxt;
  logic signed [Z_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, zin_r;
  logic [SCORE_W-1:0] winner_s_r, winner_s_nxt, climb_s_r, climb_s_nxt, base_s_r, base_s_nxt;
  logic [SCORE_W-1:0] s_low_r, s_low_nxt, s_mid_r, s_mid_nxt, exp_r, exp_nxt;
  logic [SCORE_W-1:0] ein_r, sin_r;
  logic        wvalid_r, wvalid_nxt, down_r, down_nxt, swept_r, swept_nxt, neg_r, neg_nxt;
  logic        ok_r, ok_nxt;
  logic [7:0]  steps_r, steps_nxt;
  logic [FRAME_W-1:0] frames_r, frames_nxt;
  logic [1:0]  cmd_r;
  logic [47:0] sig_r, sig_nxt, num_r, num_nxt;
  logic [34:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  logic out_free, in_acc, emit_go, e_kind, do_sweep;
  logic signed [Z_W-1:0] e_z, sw_c, sw_lo, sw_hi;
  logic [SCORE_W-1:0] e_score;
  logic out_tvalid_r;
  logic [71:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  assign out_free = !out_tvalid_r || out_tready;
  assign in_tready = (st_r == S_WAIT);
  assign in_acc = in_tvalid && in_tready;

  // combinational helpers
  logic [15:0] cs;
  logic signed [ZX_W-1:0] c_next, zn;
  logic zn_ok, s_gt_w;
  logic [34:0] denom, negd;
  logic [SCORE_W-1:0] absn;
  logic [35:0] r2;
  logic signed [ZX_W-1:0] off;

  always_comb begin
    cs = (coarse_r == 16'd0) ? 16'd1 : coarse_r;
    sw_c = (st_r == S_EXEC) ? zin_r : centre_r;
    sw_lo = clampz(zext(sw_c) - (ZX_W)'(half_r));
    sw_hi = clampz(zext(sw_c) + (ZX_W)'(half_r));
    c_next = zext(probe_r) + (ZX_W)'(cs);
    zn = down_r ? zext(climb_z_r) - (ZX_W)'(fine_r) : zext(climb_z_r) + (ZX_W)'(fine_r);
    zn_ok = (zn >= zext(lo_r) - $signed((ZX_W)'(cs))) &&
            (zn <= zext(hi_r) + $signed((ZX_W)'(cs))) &&
            (zn >= ZMIN_X) && (zn <= ZMAX_X);
    s_gt_w = !wvalid_r || (sin_r > winner_s_r);
    // second difference of the verify triple, 35-bit signed
    denom = {3'd0, s_low_r} + {3'd0, sin_r} - {2'd0, s_mid_r, 1'b0};
    negd = -denom;
    absn = (s_low_r > sin_r) ? s_low_r - sin_r : sin_r - s_low_r;
    r2 = {rem_r, num_r[47]};
    off = neg_r ? -(ZX_W)'(num_r[16:0]) : (ZX_W)'(num_r[16:0]);
  end

  always_comb begin
    st_nxt = st_r; phase_nxt = phase_r;
    probe_nxt = probe_r; centre_nxt = centre_r; winner_z_nxt = winner_z_r;
    climb_z_nxt = climb_z_r; base_z_nxt = base_z_r; lo_nxt = lo_r; hi_nxt = hi_r;
    winner_s_nxt = winner_s_r; climb_s_nxt = climb_s_r; base_s_nxt = base_s_r;
    s_low_nxt = s_low_r; s_mid_nxt = s_mid_r; exp_nxt = exp_r;
    wvalid_nxt = wvalid_r; down_nxt = down_r; swept_nxt = swept_r; neg_nxt = neg_r;
    ok_nxt = ok_r; steps_nxt = steps_r; frames_nxt = frames_r;
    sig_nxt = sig_r; num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    emit_go = 1'b0; e_kind = 1'b0; e_z = probe_r; e_score = '0; do_sweep = 1'b0;

    case (st_r)
      S_WAIT: if (in_acc) st_nxt = S_EXEC;
      S_EXEC: if (out_free) begin
        st_nxt = S_WAIT;
        case (cmd_r)
          CMD_SWEEP: begin
            frames_nxt = '0;
            do_sweep = 1'b1;
          end
          CMD_MAP: begin
            frames_nxt = '0;
            swept_nxt = 1'b0;
            centre_nxt = zin_r;
            exp_nxt = ein_r;
            emit_go = 1'b1;
            if (!verify_en_r) begin
              phase_nxt = PH_TRUST;
              e_z = zin_r;
            end else begin
              phase_nxt = PH_VLO;
              e_z = clampz(zext(zin_r) - (ZX_W)'(span_r));
            end
          end
          CMD_SCORE: if (phase_r != PH_IDLE) begin
            if (frames_r != '1) frames_nxt = frames_r + 1'b1;
            case (phase_r)
              PH_TRUST: begin
                phase_nxt = PH_IDLE;
                emit_go = 1'b1; e_kind = 1'b1; e_z = centre_r; e_score = sin_r;
              end
              PH_VLO: begin
                s_low_nxt = sin_r; phase_nxt = PH_VMID;
                emit_go = 1'b1; e_z = centre_r;
              end
              PH_VMID: begin
                s_mid_nxt = sin_r; phase_nxt = PH_VHI;
                emit_go = 1'b1; e_z = clampz(zext(centre_r) + (ZX_W)'(span_r));
              end
              PH_VHI: st_nxt = S_VMUL;
              PH_CONFIRM: begin
                phase_nxt = PH_IDLE;
                emit_go = 1'b1; e_kind = 1'b1;
                if (sin_r >= s_mid_r) begin
                  e_z = probe_r; e_score = sin_r;
                end else begin
                  e_z = centre_r; e_score = s_mid_r;
                end
              end
              PH_COARSE: begin
                if (s_gt_w) begin
                  winner_s_nxt = sin_r; winner_z_nxt = probe_r;
                end
                wvalid_nxt = 1'b1;
                if (c_next <= zext(hi_r)) begin
                  probe_nxt = c_next[Z_W-1:0];
                  emit_go = 1'b1; e_z = c_next[Z_W-1:0];
                end else begin
                  base_z_nxt = winner_z_nxt; climb_z_nxt = winner_z_nxt;
                  base_s_nxt = winner_s_nxt; climb_s_nxt = winner_s_nxt;
                  steps_nxt = '0; down_nxt = 1'b0;
                  st_nxt = S_CLIMB;
                end
              end
              default: begin
                if (sin_r <= climb_s_r) steps_nxt = max_fine_r;
                else begin
                  climb_z_nxt = probe_r; climb_s_nxt = sin_r;
                end
                st_nxt = S_CLIMB;
              end
            endcase
          end
          default: ;
        endcase
      end
      S_CLIMB: if (out_free) begin
        if (steps_r < max_fine_r && zn_ok) begin
          steps_nxt = steps_r + 1'b1;
          probe_nxt = zn[Z_W-1:0];
          phase_nxt = PH_CLIMB;
          emit_go = 1'b1; e_z = zn[Z_W-1:0];
          st_nxt = S_WAIT;
        end else begin
          if (climb_s_r > winner_s_r) begin
            winner_s_nxt = climb_s_r; winner_z_nxt = climb_z_r;
          end
          if (!down_r) begin
            // turn around at the coarse winner
            down_nxt = 1'b1; climb_z_nxt = base_z_r; climb_s_nxt = base_s_r; steps_nxt = '0;
          end else begin
            phase_nxt = PH_IDLE;
            emit_go = 1'b1; e_kind = 1'b1; e_z = winner_z_nxt; e_score = winner_s_nxt;
            st_nxt = S_WAIT;
          end
        end
      end
      S_VMUL: begin
        ok_nxt = denom[34] && ({3'd0, absn} <= {negd[33:0], 1'b0});
        neg_nxt = s_low_r > sin_r;
        num_nxt = absn * span_r;
        sig_nxt = ratio_r * exp_r;
        den_nxt = {negd[33:0], 1'b0};
        st_nxt = S_VDEC;
      end
      S_VDEC: if (out_free) begin
        if (ok_r && (exp_r == '0 || {s_mid_r, 16'd0} > sig_r)) begin
          rem_nxt = '0; cnt_nxt = '0; st_nxt = S_DIV;
        end else begin
          do_sweep = 1'b1; st_nxt = S_WAIT;
        end
      end
      S_DIV: begin
        if (r2 >= {1'b0, den_r}) begin
          rem_nxt = 35'(r2 - {1'b0, den_r});
          num_nxt = {num_r[46:0], 1'b1};
        end else begin
          rem_nxt = r2[34:0];
          num_nxt = {num_r[46:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'd47) st_nxt = S_VERT;
      end
      S_VERT: if (out_free) begin
        probe_nxt = clampz(zext(centre_r) + off);
        phase_nxt = PH_CONFIRM;
        emit_go = 1'b1; e_z = probe_nxt;
        st_nxt = S_WAIT;
      end
      default: st_nxt = S_WAIT;
    endcase

    if (do_sweep) begin
      centre_nxt = sw_c; lo_nxt = sw_lo; hi_nxt = sw_hi;
      wvalid_nxt = 1'b0; winner_z_nxt = sw_lo; probe_nxt = sw_lo;
      swept_nxt = 1'b1; phase_nxt = PH_COARSE;
      emit_go = 1'b1; e_kind = 1'b0; e_z = sw_lo; e_score = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_WAIT; phase_r <= PH_IDLE;
      probe_r <= '0; centre_r <= '0; winner_z_r <= '0; climb_z_r <= '0; base_z_r <= '0;
      lo_r <= '0; hi_r <= '0;
      winner_s_r <= '0; wvalid_r <= 1'b0; climb_s_r <= '0; base_s_r <= '0;
      s_low_r <= '0; s_mid_r <= '0; exp_r <= '0;
      down_r <= 1'b0; swept_r <= 1'b0; steps_r <= '0; frames_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; phase_r <= phase_nxt;
      probe_r <= probe_nxt; centre_r <= centre_nxt; winner_z_r <= winner_z_nxt;
      climb_z_r <= climb_z_nxt; base_z_r <= base_z_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
      winner_s_r <= winner_s_nxt; wvalid_r <= wvalid_nxt;
      climb_s_r <= climb_s_nxt; base_s_r <= base_s_nxt;
      s_low_r <= s_low_nxt; s_mid_r <= s_mid_nxt; exp_r <= exp_nxt;
      down_r <= down_nxt; swept_r <= swept_nxt; steps_r <= steps_nxt; frames_r <= frames_nxt;
      if (emit_go) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tuser;
      zin_r <= in_tdata[23:0];
      ein_r <= in_tdata[55:24];
      sin_r <= in_tdata[87:56];
    end
    ok_r <= ok_nxt; neg_r <= neg_nxt;
    sig_r <= sig_nxt; num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    if (emit_go) begin
      out_tdata_r <= {frames_nxt, e_score, e_z};
      out_tuser_r <= {swept_nxt, e_kind};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (den_r != '0)) else $error("vertex divisor is zero");
  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (phase_r == PH_VHI)) else $error("divide outside verify");
  a_climb_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLIMB) |-> (phase_r == PH_COARSE || phase_r == PH_CLIMB))
    else $error("climb step outside sweep");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_tuser_r[0] == (phase_r == PH_IDLE)))
    else $error("done result does not match idle phase");

endmodule

/* verif/afss_checker.sv */
// Watches the sequencer's channels, predicts each result and compares it.
module afss_checker
  import afss_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [87:0]  in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [71:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending
);

  localparam logic KIND_GRAB = 1'b0;
  localparam logic KIND_DONE = 1'b1;
  localparam longint ZHI = (64'sd1 <<< (Z_W - 1)) - 1;
  localparam longint ZLO = -ZHI - 1;

  typedef struct packed {
    logic                 kind;
    logic [Z_W-1:0]       z;
    logic [SCORE_W-1:0]   score;
    logic [FRAME_W-1:0]   frames;
    logic                 swept;
  } focus_step_t;

  focus_step_t expected_steps[$];

  // register copies
  longint unsigned half_range, coarse_inc_reg, fine_inc_reg, max_fine, verify_en, span, ratio;

  // search state
  logic [2:0]      ph;
  longint          probe_z, centre_z, winner_z, winner_score, climb_z, base_z;
  longint          climb_score, base_score, sweep_lo, sweep_hi;
  longint unsigned climb_steps, score_low, score_mid, expected_hold;
  int unsigned     frames;
  bit              climb_down, swept;

  function automatic longint zclamp(longint v);
    return v < ZLO ? ZLO : (v > ZHI ? ZHI : v);
  endfunction

  function automatic longint coarse_eff();
    return coarse_inc_reg == 0 ? 64'sd1 : longint'(coarse_inc_reg);
  endfunction

  function automatic focus_step_t mk_step(logic kind, longint z, longint unsigned sc);
    focus_step_t r;
    r.kind   = kind;
    r.z      = z[Z_W-1:0];
    r.score  = sc[SCORE_W-1:0];
    r.frames = frames[FRAME_W-1:0];
    r.swept  = swept;
    return r;
  endfunction

  function automatic focus_step_t begin_sweep(longint centre);
    centre_z     = centre;
    sweep_lo     = zclamp(centre - longint'(half_range));
    sweep_hi     = zclamp(centre + longint'(half_range));
    winner_score = -1;
    winner_z     = sweep_lo;
    probe_z      = sweep_lo;
    swept        = 1'b1;
    ph           = PH_COARSE;
    return mk_step(KIND_GRAB, probe_z, 0);
  endfunction

  function automatic focus_step_t climb_step();
    longint zn;
    forever begin
      if (climb_steps < max_fine) begin
        zn = climb_down ? climb_z - longint'(fine_inc_reg) : climb_z + longint'(fine_inc_reg);
        if (zn >= sweep_lo - coarse_eff() && zn <= sweep_hi + coarse_eff() &&
            zn >= ZLO && zn <= ZHI) begin
          climb_steps++;
          probe_z = zn;
          ph = PH_CLIMB;
          return mk_step(KIND_GRAB, zn, 0);
        end
      end
      if (climb_score > winner_score) begin
        winner_score = climb_score;
        winner_z = climb_z;
      end
      if (!climb_down) begin
        climb_down  = 1'b1;
        climb_z     = base_z;
        climb_score = base_score;
        climb_steps = 0;
      end else begin
        ph = PH_IDLE;
        return mk_step(KIND_DONE, winner_z, longint'(winner_score));
      end
    end
  endfunction

  function automatic focus_step_t verify_outcome(longint unsigned s_hi);
    longint lo, mid, hi, denom, off;
    longint unsigned absn, q;
    bit concave, bracket, sig;
    lo = longint'(score_low);
    mid = longint'(score_mid);
    hi = longint'(s_hi);
    denom = lo - 2 * mid + hi;
    absn = lo > hi ? lo - hi : hi - lo;
    concave = denom < 0;
    bracket = concave && absn <= 2 * longint'(-denom);
    sig = expected_hold == 0 || (score_mid << 16) > ratio * expected_hold;
    if (!concave || !bracket || !sig) return begin_sweep(centre_z);
    q = absn * span / (2 * longint'(-denom));
    off = lo > hi ? -longint'(q) : longint'(q);
    probe_z = zclamp(centre_z + off);
    ph = PH_CONFIRM;
    return mk_step(KIND_GRAB, probe_z, 0);
  endfunction

  // returns 1 when the item yields a result
  function automatic bit next_focus_step(logic [1:0] cmd, longint z, longint unsigned exp_s,
                                         longint unsigned s, output focus_step_t r);
    longint nxt;
    r = '0;
    if (cmd == CMD_SWEEP) begin
      frames = 0;
      r = begin_sweep(z);
      return 1'b1;
    end
    if (cmd == CMD_MAP) begin
      frames = 0;
      swept = 1'b0;
      centre_z = z;
      expected_hold = exp_s;
      if (verify_en == 0) begin
        ph = PH_TRUST;
        r = mk_step(KIND_GRAB, z, 0);
      end else begin
        ph = PH_VLO;
        r = mk_step(KIND_GRAB, zclamp(z - longint'(span)), 0);
      end
      return 1'b1;
    end
    if (cmd != CMD_SCORE || ph == PH_IDLE) return 1'b0;
    if (frames < 65535) frames++;
    case (ph)
      PH_TRUST: begin
        ph = PH_IDLE;
        r = mk_step(KIND_DONE, centre_z, s);
      end
      PH_VLO: begin
        score_low = s;
        ph = PH_VMID;
        r = mk_step(KIND_GRAB, centre_z, 0);
      end
      PH_VMID: begin
        score_mid = s;
        ph = PH_VHI;
        r = mk_step(KIND_GRAB, zclamp(centre_z + longint'(span)), 0);
      end
      PH_VHI: r = verify_outcome(s);
      PH_CONFIRM: begin
        ph = PH_IDLE;
        if (s >= score_mid) r = mk_step(KIND_DONE, probe_z, s);
        else r = mk_step(KIND_DONE, centre_z, score_mid);
      end
      PH_COARSE: begin
        nxt = probe_z + coarse_eff();
        if (longint'(s) > winner_score) begin
          winner_score = longint'(s);
          winner_z = probe_z;
        end
        if (nxt <= sweep_hi) begin
          probe_z = nxt;
          r = mk_step(KIND_GRAB, nxt, 0);
        end else begin
          base_z = winner_z;
          climb_z = winner_z;
          base_score = winner_score;
          climb_score = winner_score;
          climb_steps = 0;
          climb_down = 1'b0;
          r = climb_step();
        end
      end
      default: begin
        if (longint'(s) <= climb_score) climb_steps = max_fine;
        else begin
          climb_z = probe_z;
          climb_score = longint'(s);
        end
        r = climb_step();
      end
    endcase
    return 1'b1;
  endfunction

  task automatic flag(string what, longint unsigned e, longint unsigned a);
    $display("%0t: %s expected %0h got %0h", $time, what, e, a);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_steps.size();

  always @(posedge clk) begin
    focus_step_t got, exp_r, res;
    if (!rst_n) begin
      half_range = 2000; coarse_inc_reg = 200; fine_inc_reg = 25; max_fine = 8;
      verify_en = 1; span = 100; ratio = 5243;
      ph = PH_IDLE;
      probe_z = 0; centre_z = 0; winner_z = 0; climb_z = 0; base_z = 0;
      winner_score = -1; climb_score = 0; base_score = 0; sweep_lo = 0; sweep_hi = 0;
      climb_steps = 0; climb_down = 0; swept = 0;
      score_low = 0; score_mid = 0; expected_hold = 0; frames = 0;
      expected_steps.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_HALF_RANGE: half_range     = cfg_pwdata[19:0];
          REG_COARSE:     coarse_inc_reg = cfg_pwdata[15:0];
          REG_FINE:       fine_inc_reg   = cfg_pwdata[15:0];
          REG_MAX_FINE:   max_fine       = cfg_pwdata[7:0];
          REG_VERIFY_EN:  verify_en      = cfg_pwdata[0];
          REG_SPAN:       span           = cfg_pwdata[15:0];
          REG_RATIO:      ratio          = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tdata[23:0], out_tdata[55:24], out_tdata[71:56], out_tuser[1]};
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result, expected none got %0h", $time, got);
          fail_count++;
        end else begin
          exp_r = expected_steps.pop_front();
          if (got.kind != exp_r.kind) flag("kind", exp_r.kind, got.kind);
          if (got.z != exp_r.z) flag("target_z", exp_r.z, got.z);
          if (got.score != exp_r.score) flag("best_score", exp_r.score, got.score);
          if (got.frames != exp_r.frames) flag("frame_count", exp_r.frames, got.frames);
          if (got.swept != exp_r.swept) flag("sweep flag", exp_r.swept, got.swept);
        end
      end
      if (in_tvalid && in_tready) begin
        if (next_focus_step(in_tuser, longint'($signed(in_tdata[23:0])), in_tdata[55:24],
                            in_tdata[87:56], res))
          expected_steps.insert(expected_steps.size(), res);
      end
    end
  end

endmodule

/* verif/autofocus_search_sequencer_tb.sv */
// Stimulus and verdict for the autofocus search sequencer.
module autofocus_search_sequencer_tb;
  import afss_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int LIMIT = 1500000;
  localparam int PHASE_ITEMS = 55;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count, pending;
  int cycles = 0;
  int accepted = 0;
  int burst_left = 0;
  bit long_hold_done = 1'b0;
  int unsigned cur_half, cur_coarse, cur_max_fine;

  autofocus_search_sequencer u_dut (.*);

  afss_checker u_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: runs of ready and stall, plus one long hold-off
  initial begin
    int run;
    @(posedge rst_n);
    forever begin
      if (!long_hold_done && cycles > 4000) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold_done = 1'b1;
      end
      run = $urandom_range(0, 9) == 0 ? $urandom_range(30, 120) : $urandom_range(1, 12);
      @(negedge clk) out_tready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      run = $urandom_range(0, 5);
      if (run > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk) cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic load_config(int unsigned half, int unsigned coarse, int unsigned fine,
                             int unsigned mf, int unsigned ven, int unsigned sp,
                             int unsigned rat);
    reg_write(REG_HALF_RANGE, half);
    reg_write(REG_COARSE, coarse);
    reg_write(REG_FINE, fine);
    reg_write(REG_MAX_FINE, mf);
    reg_write(REG_VERIFY_EN, ven);
    reg_write(REG_SPAN, sp);
    reg_write(REG_RATIO, rat);
    cur_half = half;
    cur_coarse = coarse == 0 ? 1 : coarse;
    cur_max_fine = mf;
  endtask

  task automatic send_item(logic [1:0] cmd, logic [23:0] z, logic [31:0] exp_s,
                           logic [31:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk) in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {s, exp_s, z};
    #1;
    while (!in_tready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    accepted++;
  endtask

  function automatic logic [31:0] rand_score();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic logic [23:0] rand_z();
    case ($urandom_range(0, 4))
      0: return 24'(24'h7F_FFFF - $urandom_range(0, 3000));
      1: return 24'(24'h80_0000 + $urandom_range(0, 3000));
      2: return 24'($urandom());
      default: return 24'($urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  task automatic sweep_reports(int cap);
    int n;
    n = 2 * cur_half / cur_coarse + 2 * cur_max_fine + 3;
    if (n > cap) n = cap;
    if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
    repeat (n) send_item(CMD_SCORE, 24'($urandom()), $urandom(), rand_score());
  endtask

  task automatic map_search();
    logic [31:0] lo, mid, hi, exp_s;
    lo = $urandom_range(0, 1 << 30);
    mid = lo + $urandom_range(1, 1 << 20);
    hi = lo + $urandom_range(0, 1 << 19) - (1 << 18);
    case ($urandom_range(0, 3))
      0: exp_s = 0;
      1: exp_s = $urandom();
      default: exp_s = mid >> $urandom_range(0, 8);
    endcase
    if ($urandom_range(0, 4) == 0) begin
      lo = rand_score();
      mid = rand_score();
      hi = rand_score();
    end
    send_item(CMD_MAP, rand_z(), exp_s, $urandom());
    send_item(CMD_SCORE, 24'($urandom()), $urandom(), lo);
    send_item(CMD_SCORE, 24'($urandom()), $urandom(), mid);
    send_item(CMD_SCORE, 24'($urandom()), $urandom(), hi);
    send_item(CMD_SCORE, 24'($urandom()), $urandom(), rand_score());
    if ($urandom_range(0, 1) == 0) sweep_reports(40);
  endtask

  task automatic run_phase(int target);
    int start_count;
    start_count = accepted;
    while (accepted - start_count < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: map_search();
        4, 5, 6, 7: begin
          send_item(CMD_SWEEP, rand_z(), $urandom(), $urandom());
          sweep_reports(60);
        end
        8: send_item(CMD_NONE, 24'($urandom()), $urandom(), $urandom());
        default: send_item(CMD_SCORE, 24'($urandom()), $urandom(), rand_score());
      endcase
    end
    @(negedge clk) in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    cur_half = 2000;
    cur_coarse = 200;
    cur_max_fine = 8;

    // directed: extremes of every field, every command, idle reports, unknown command
    send_item(CMD_SCORE, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_NONE, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_MAP, 24'h80_0000, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'd100);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'd300);
    send_item(CMD_SWEEP, 24'h7F_FFFF, 32'h0, 32'h0);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(CMD_MAP, 24'h7F_FFF0, 32'h0, 32'h0);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'd1000);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'd5000);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'd1200);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'd4000);
    send_item(CMD_MAP, 24'h00_0000, 32'd1, 32'h0);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'd10);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'd10);
    send_item(CMD_SCORE, 24'h0, 32'h0, 32'd10);
    run_phase(PHASE_ITEMS);

    load_config(0, 0, 1, 255, 0, 0, 0);
    run_phase(PHASE_ITEMS);
    load_config(20'hF_FFFF, 16'hFFFF, 16'hFFFF, 255, 1, 16'hFFFF, 16'hFFFF);
    run_phase(PHASE_ITEMS);
    load_config(50, 7, 3, 4, 1, 20, 100);
    run_phase(PHASE_ITEMS);
    load_config(300, 100, 40, 0, 0, 1, 30000);
    run_phase(PHASE_ITEMS);
    load_config($urandom_range(0, 600), $urandom_range(1, 300), $urandom_range(1, 100),
                $urandom_range(0, 10), 1, $urandom_range(1, 500), $urandom_range(0, 65535));
    run_phase(PHASE_ITEMS);

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
